// ===== design/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared widths, opcodes and sequencer states for the scc unit
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxEdges = 256;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned EdgeW    = $clog2(MaxEdges);
  localparam int unsigned CountW   = EdgeW + 1;
  localparam int unsigned TimeW    = NodeW + 1;
  localparam int unsigned CfgW     = 7;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [CountW-1:0] ecnt_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [NodeW:0]    depth_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_INIT  = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_CHK   = 10'b00_0000_1000,
    S_TEST  = 10'b00_0001_0000,
    S_DONE  = 10'b00_0010_0000,
    S_POPRD = 10'b00_0100_0000,
    S_POP   = 10'b00_1000_0000,
    S_RET   = 10'b01_0000_0000,
    S_LOAD  = 10'b10_0000_0000
  } state_e;

endpackage

// ===== design/strongly_connected_components_unit.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components_unit
// tarjan scc search over a loaded edge list
// ----------------------------------------------------------------------------
// Words are commands: clear and add edge are taken while idle and busy_o
// stays low, so they can follow back to back. A run walks the graph depth first
// from node 0 with one shared sequencer and keeps busy_o high throughout. It
// first clears the per-node marks of all MaxNodes (64) nodes. Every frame then
// reads the edge store once from its cursor to the end, with a registered edge
// read and then a match check per edge, plus a registered mark read and
// decision for an edge that leaves the frame's node. It then sees the end of
// the store, tests for a component root, reads and pops each node of a found
// component, returns and reloads the parent frame, if any. Each found node
// appears for one cycle with result_valid_o; the receiver cannot stall, so
// results are never held back. Components come out in stack-pop order;
// last_in_group_o marks the last node of a component and last_of_run_o the
// final result of the run.
// ----------------------------------------------------------------------------
module strongly_connected_components_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  op_i,
  input  scc_pkg::node_t              from_node_i,
  input  scc_pkg::node_t              to_node_i,
  input  logic                        cfg_we_i,
  input  logic [scc_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                        result_valid_o,
  output scc_pkg::node_t              node_id_o,
  output logic                        last_in_group_o,
  output logic                        last_of_run_o,
  output logic                        edge_overflow_o
);
  import scc_pkg::*;

  // edge list
  node_t src_mem [MaxEdges];
  node_t dst_mem [MaxEdges];
  // per-node marks of the current run
  time_t disc_mem [MaxNodes];
  logic  onst_mem [MaxNodes];
  // node stack and call frames (node, cursor, lowlink, discovery)
  node_t stk_mem [MaxNodes];
  node_t frn_mem [MaxNodes];
  ecnt_t frc_mem [MaxNodes];
  time_t frl_mem [MaxNodes];
  time_t frd_mem [MaxNodes];

  state_e          state_q, state_d;
  ecnt_t           held_q;
  logic            drop_q;
  logic [CfgW-1:0] cnt_cfg_q;
  logic [CfgW-1:0] live;
  depth_t          sp_q, fp_q;
  time_t           clk_now_q;
  time_t           clk_next;
  node_t           clr_q;
  node_t           v_q;        // node of the top frame
  ecnt_t           cur_q;      // edge cursor of the top frame
  time_t           v_low_q, v_disc_q;
  node_t           es_q, ed_q; // registered edge read
  time_t           wdisc_q;    // registered marks of the edge target
  logic            wonst_q;
  node_t           x_q;        // node being popped
  node_t           pn_q;       // parent frame read back on return
  ecnt_t           pc_q;
  time_t           pl_q, pd_q;
  node_t           sp_top, fp_top, fp_par;
  logic            accept;
  logic            add_ok;
  logic            edge_hit;
  logic            new_node;

  // effective node count
  always_comb begin
    if (cnt_cfg_q == '0) live = CfgW'(1);
    else if (cnt_cfg_q > CfgW'(MaxNodes)) live = CfgW'(MaxNodes);
    else live = cnt_cfg_q;
  end

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign add_ok = accept && (op_i == OP_ADD) && (held_q < ecnt_t'(MaxEdges))
                  && ({1'b0, from_node_i} < live) && ({1'b0, to_node_i} < live);

  // edge from the top frame's node with both ends in range
  assign edge_hit = (es_q == v_q) && ({1'b0, es_q} < live) && ({1'b0, ed_q} < live);
  assign new_node = (wdisc_q == '0);

  assign clk_next = clk_now_q + 1'b1;
  assign sp_top   = sp_q[NodeW-1:0] - 1'b1;
  assign fp_top   = fp_q[NodeW-1:0] - 1'b1;
  assign fp_par   = fp_q[NodeW-1:0] - 2'd2;

  // edge store and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      drop_q    <= 1'b0;
      cnt_cfg_q <= CfgW'(MaxNodes);
    end else begin
      if (cfg_we_i) cnt_cfg_q <= cfg_wdata_i;
      if (accept && op_i == OP_CLEAR) begin
        held_q <= '0;
        drop_q <= 1'b0;
      end else if (add_ok) begin
        held_q <= held_q + 1'b1;
      end else if (accept && op_i == OP_ADD) begin
        drop_q <= 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && op_i == OP_RUN) state_d = S_INIT;
      S_INIT:  if (clr_q == node_t'(MaxNodes-1)) state_d = S_SCAN;
      S_SCAN:  state_d = (cur_q < held_q) ? S_CHK : S_DONE;
      S_CHK:   state_d = edge_hit ? S_TEST : S_SCAN;
      S_TEST:  state_d = S_SCAN;
      S_DONE:  state_d = (v_low_q == v_disc_q) ? S_POPRD : S_RET;
      S_POPRD: state_d = S_POP;
      S_POP:   state_d = (x_q == v_q) ? S_RET : S_POPRD;
      S_RET:   state_d = (fp_q == depth_t'(1)) ? S_IDLE : S_LOAD;
      S_LOAD:  state_d = S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      clr_q           <= '0;
      sp_q            <= '0;
      fp_q            <= '0;
      clk_now_q       <= '0;
      v_q             <= '0;
      cur_q           <= '0;
      v_low_q         <= '0;
      v_disc_q        <= '0;
      result_valid_o  <= 1'b0;
      node_id_o       <= '0;
      last_in_group_o <= 1'b0;
      last_of_run_o   <= 1'b0;
      edge_overflow_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          // root frame is node 0 with discovery time 1
          if (accept && op_i == OP_RUN) begin
            clr_q     <= '0;
            sp_q      <= depth_t'(1);
            fp_q      <= depth_t'(1);
            clk_now_q <= time_t'(1);
            v_q       <= '0;
            cur_q     <= '0;
            v_low_q   <= time_t'(1);
            v_disc_q  <= time_t'(1);
          end
        end
        S_INIT: begin
          clr_q <= clr_q + 1'b1;
        end
        S_SCAN: begin
          if (cur_q < held_q) cur_q <= cur_q + 1'b1;
        end
        S_TEST: begin
          if (new_node) begin
            // descend into the unvisited target
            clk_now_q <= clk_next;
            sp_q      <= sp_q + 1'b1;
            fp_q      <= fp_q + 1'b1;
            v_q       <= ed_q;
            cur_q     <= '0;
            v_low_q   <= clk_next;
            v_disc_q  <= clk_next;
          end else if (wonst_q && wdisc_q < v_low_q) begin
            v_low_q <= wdisc_q;
          end
        end
        S_POP: begin
          sp_q            <= sp_q - 1'b1;
          result_valid_o  <= 1'b1;
          node_id_o       <= x_q;
          last_in_group_o <= (x_q == v_q);
          last_of_run_o   <= (x_q == v_q) && (fp_q == depth_t'(1));
          edge_overflow_o <= drop_q;
        end
        S_RET: begin
          fp_q <= fp_q - 1'b1;
        end
        S_LOAD: begin
          // parent resumes with the smaller of its own and the child's lowlink
          v_q      <= pn_q;
          cur_q    <= pc_q;
          v_disc_q <= pd_q;
          v_low_q  <= (v_low_q < pl_q) ? v_low_q : pl_q;
        end
        default: ;
      endcase
    end
  end

  // memories and their registered read data
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (add_ok) begin
          src_mem[held_q[EdgeW-1:0]] <= from_node_i;
          dst_mem[held_q[EdgeW-1:0]] <= to_node_i;
        end
      end
      S_INIT: begin
        // clearing pass, node 0 is marked visited on the way
        disc_mem[clr_q] <= (clr_q == '0) ? time_t'(1) : '0;
        onst_mem[clr_q] <= (clr_q == '0);
        if (clr_q == '0) begin
          stk_mem[0] <= '0;
          frn_mem[0] <= '0;
          frd_mem[0] <= time_t'(1);
        end
      end
      S_SCAN: begin
        es_q <= src_mem[cur_q[EdgeW-1:0]];
        ed_q <= dst_mem[cur_q[EdgeW-1:0]];
      end
      S_CHK: begin
        wdisc_q <= disc_mem[ed_q];
        wonst_q <= onst_mem[ed_q];
      end
      S_TEST: begin
        if (new_node) begin
          disc_mem[ed_q]           <= clk_next;
          onst_mem[ed_q]           <= 1'b1;
          stk_mem[sp_q[NodeW-1:0]] <= ed_q;
          frc_mem[fp_top]          <= cur_q;
          frl_mem[fp_top]          <= v_low_q;
          frn_mem[fp_q[NodeW-1:0]] <= ed_q;
          frd_mem[fp_q[NodeW-1:0]] <= clk_next;
        end
      end
      S_POPRD: begin
        x_q <= stk_mem[sp_top];
      end
      S_POP: begin
        onst_mem[x_q] <= 1'b0;
      end
      S_RET: begin
        pn_q <= frn_mem[fp_par];
        pc_q <= frc_mem[fp_par];
        pl_q <= frl_mem[fp_par];
        pd_q <= frd_mem[fp_par];
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_RUN) |=> busy_o)
    else $error("run not started");
  a_res_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result outside a run");
  a_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_run_o) |-> last_in_group_o)
    else $error("run end not a group end");
`endif

endmodule
